>>> design/wbps_pkg.sv
// Package for the wildcard byte pattern scanner.
// Holds sizes, register indexes, status codes and the configuration struct.
// No dependencies.
`default_nettype none

package wbps_pkg;

    localparam int PATTERN_MAX  = 16;
    localparam int OFFSET_BITS  = 32;
    localparam int OUT_OFF_W    = 32;
    localparam int LEN_W        = 5;
    localparam int WIN_IDX_W    = $clog2(PATTERN_MAX);
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_ADDR_W   = 5;
    localparam int S_TDATA_W    = 8;
    localparam int M_TDATA_W    = 40;

    localparam logic [OFFSET_BITS-1:0] CNT_LIMIT = '1;

    typedef enum logic [1:0] {
        REG_PAT_LOW  = 2'd0,
        REG_PAT_HIGH = 2'd1,
        REG_CARE     = 2'd2,
        REG_LEN      = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_FOUND    = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

    typedef struct packed {
        logic [8*PATTERN_MAX-1:0] pattern;
        logic [PATTERN_MAX-1:0]   care;
        logic [LEN_W-1:0]         len;
    } t_cfg;

    function automatic logic [LEN_W-1:0] used_len(input logic [LEN_W-1:0] len);
        if (len > LEN_W'(PATTERN_MAX)) begin
            return LEN_W'(PATTERN_MAX);
        end
        return len;
    endfunction

endpackage

`default_nettype wire

>>> design/wildcard_byte_pattern_scan.sv
// Wildcard byte pattern scanner: one byte per beat through a 16-byte shift window.
// Takes one beat per cycle when the output is not stalled; gives one result beat per
// region: at its first match, else at region end. Window and byte counter register at input
// accept; the masked compare of all positions runs in parallel into the result register.
// Depends on wbps_pkg and wbps_cfg.
`default_nettype none

module wildcard_byte_pattern_scan (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // slave side tdata: [7:0] data_byte; tlast: region_end
    input  wire logic                            i_s_tvalid,
    output logic                                 o_s_tready,
    input  wire logic [wbps_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input  wire logic                            i_s_tlast,
    // master side tdata: [1:0] scan_status, [33:2] match_offset, [39:34] zero
    output logic                                 o_m_tvalid,
    input  wire logic                            i_m_tready,
    output logic      [wbps_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [wbps_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [wbps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                 pready
);
    import wbps_pkg::*;

    t_cfg cfg;

    wbps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    logic [7:0]             r_win [PATTERN_MAX];
    logic [OFFSET_BITS-1:0] r_cnt;
    logic                   r_ovf;
    logic                   r_last;
    logic                   r_clr;
    logic                   r_s1_valid;
    logic                   r_match;
    logic                   r_out_valid;
    t_status                r_status;
    logic [OUT_OFF_W-1:0]   r_offset;

    logic                   in_acc;
    logic                   fire;
    logic [OFFSET_BITS-1:0] cnt_base;
    logic                   n_ovf;
    logic [OFFSET_BITS-1:0] n_cnt;
    logic [LEN_W-1:0]       len;
    logic                   pat_ok;
    logic [PATTERN_MAX-1:0] pos_ok;
    logic                   hit;
    logic                   emit;
    logic [WIN_IDX_W-1:0]   widx [PATTERN_MAX];

    assign fire       = r_s1_valid & (~r_out_valid | i_m_tready);
    assign o_s_tready = ~r_s1_valid | fire;
    assign in_acc     = i_s_tvalid & o_s_tready;

    always_comb begin
        cnt_base = r_clr ? '0 : r_cnt;
        n_ovf    = (cnt_base == CNT_LIMIT);
        n_cnt    = n_ovf ? cnt_base : cnt_base + OFFSET_BITS'(1);
    end

    always_comb begin
        len    = used_len(cfg.len);
        pat_ok = (len != '0) & cfg.care[0];
        for (int j = 0; j < PATTERN_MAX; j++) begin
            widx[j]   = WIN_IDX_W'(len - LEN_W'(1) - LEN_W'(j));
            pos_ok[j] = (LEN_W'(j) >= len) | ~cfg.care[j]
                        | (cfg.pattern[8*j +: 8] == r_win[widx[j]]);
        end
        hit  = pat_ok & ~r_match & ~r_ovf & (r_cnt >= OFFSET_BITS'(len)) & (&pos_ok);
        emit = hit | (r_last & ~r_match);
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_win[0] <= i_s_tdata[7:0];
            for (int k = 1; k < PATTERN_MAX; k++) begin
                r_win[k] <= r_win[k-1];
            end
            r_ovf  <= n_ovf;
            r_last <= i_s_tlast;
        end
        if (fire) begin
            r_status <= hit ? ST_FOUND : (pat_ok ? ST_NOTFOUND : ST_INVALID);
            r_offset <= hit ? OUT_OFF_W'(r_cnt - OFFSET_BITS'(len)) : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_clr       <= 1'b1;
            r_s1_valid  <= 1'b0;
            r_match     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_acc) begin
                r_cnt      <= n_cnt;
                r_clr      <= i_s_tlast;
                r_s1_valid <= 1'b1;
            end else if (fire) begin
                r_s1_valid <= 1'b0;
            end
            if (fire) begin
                r_match     <= r_last ? 1'b0 : (r_match | hit);
                r_out_valid <= emit;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'({r_offset, r_status});

endmodule

`default_nettype wire

>>> design/wbps_cfg.sv
// APB register block for the wildcard byte pattern scanner.
// Holds pattern bytes, care mask and pattern length; uses wbps_pkg.
`default_nettype none

module wbps_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [wbps_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire logic [wbps_pkg::CFG_DATA_W-1:0] pwdata,
    output logic      [wbps_pkg::CFG_DATA_W-1:0] prdata,
    output logic                                pready,
    output wbps_pkg::t_cfg                      o_cfg
);
    import wbps_pkg::*;

    logic [63:0]            r_pat_low;
    logic [63:0]            r_pat_high;
    logic [PATTERN_MAX-1:0] r_care;
    logic [LEN_W-1:0]       r_len;
    logic                   wr_en;
    t_reg_idx               idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_low  <= '0;
            r_pat_high <= '0;
            r_care     <= '0;
            r_len      <= '0;
        end else if (wr_en) begin
            unique case (idx)
                REG_PAT_LOW:  r_pat_low  <= pwdata[63:0];
                REG_PAT_HIGH: r_pat_high <= pwdata[63:0];
                REG_CARE:     r_care     <= pwdata[PATTERN_MAX-1:0];
                REG_LEN:      r_len      <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_PAT_LOW:  prdata = r_pat_low;
            REG_PAT_HIGH: prdata = r_pat_high;
            REG_CARE:     prdata = CFG_DATA_W'(r_care);
            REG_LEN:      prdata = CFG_DATA_W'(r_len);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.pattern = {r_pat_high, r_pat_low};
    assign o_cfg.care    = r_care;
    assign o_cfg.len     = r_len;

endmodule

`default_nettype wire
